@@ src/ptrt_pkg.sv @@
// Package: shared constants and controller/datapath command and status types.
`timescale 1ns / 1ps
`default_nettype none
package ptrt_pkg;

  localparam int NUM_TASKS  = 8;
  localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int TIME_W     = 16;
  localparam int TICK_W     = 8;
  localparam int MASK_W     = 8;
  localparam int SLOT_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TICK_LENGTH = CFG_ADDR_W'(0);
  localparam logic [TICK_W-1:0]     TICK_RESET       = TICK_W'(1);

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ src/ptrt_ctrl.sv @@
// Controller: sequences load, slot scan and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module ptrt_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_mode,
  output logic               in_stall,
  input  ptrt_pkg::status_t  status,
  output ptrt_pkg::cmd_t     cmd
);
  import ptrt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/ptrt_datapath.sv @@
// Datapath: slot counters, reload periods, valid bits, fire mask and output register.
`timescale 1ns / 1ps
`default_nettype none
module ptrt_datapath (
  input  wire                           clk,
  input  wire                           rst_n,
  input  ptrt_pkg::cmd_t                cmd,
  output ptrt_pkg::status_t             status,
  input  wire [ptrt_pkg::SLOT_W-1:0]    in_slot_index,
  input  wire [ptrt_pkg::TIME_W-1:0]    in_load_start_delay,
  input  wire [ptrt_pkg::TIME_W-1:0]    in_load_period,
  input  wire [ptrt_pkg::TICK_W-1:0]    tick_length,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [ptrt_pkg::MASK_W-1:0]   out_fired_mask
);
  import ptrt_pkg::*;

  logic [TIME_W-1:0]    rem_r    [NUM_TASKS];
  logic [TIME_W-1:0]    reload_r [NUM_TASKS];
  logic [NUM_TASKS-1:0] valid_r;
  logic [IDX_W-1:0]     idx_r;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic                 out_valid_r;
  logic [MASK_W-1:0]    out_mask_r;

  logic [TIME_W-1:0]    cur_rem;
  logic [TIME_W-1:0]    rem_nxt;
  logic                 fire;
  logic                 slot_ok;
  logic [IDX_W-1:0]     load_idx;

  assign load_idx = IDX_W'(in_slot_index);
  assign slot_ok  = 32'(in_slot_index) < NUM_TASKS;
  assign cur_rem  = rem_r[idx_r];
  assign fire     = (cur_rem == '0) && valid_r[idx_r];

  always_comb begin
    if (cur_rem == '0) begin
      rem_nxt = fire ? reload_r[idx_r] : cur_rem;
    end else if (cur_rem <= TIME_W'(tick_length)) begin
      rem_nxt = '0;
    end else begin
      rem_nxt = cur_rem - TIME_W'(tick_length);
    end
  end

  assign mask_nxt = mask_r | (MASK_W'(fire) << idx_r);

  assign status.scan_last = (32'(idx_r) == NUM_TASKS - 1);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      rem_r[load_idx]    <= in_load_start_delay;
      reload_r[load_idx] <= in_load_period;
    end else if (cmd.scan_step) begin
      rem_r[idx_r] <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.load && slot_ok) begin
      valid_r[load_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.scan_start) begin
      mask_r <= '0;
      idx_r  <= '0;
    end else if (cmd.scan_step) begin
      mask_r <= mask_nxt;
      idx_r  <= status.scan_last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mask_r <= mask_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired_mask = out_mask_r;

endmodule
`default_nettype wire

@@ src/periodic_task_release_timer_top.sv @@
// Top level: APB register, controller and datapath of the periodic task release timer.
// Load request: the slot is written on acceptance, then the FINISH state loads the result register.
// Tick request: the SCAN state visits one slot per cycle over all NUM_TASKS slots, then
// FINISH loads the result register; requests are taken only in IDLE. A held result adds stalls.
// The result register lets the next request enter while a result waits to be taken.
// Reset (synchronous, rst_n low) clears all slot valid bits and sets tick length to 1.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_release_timer_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_mode,
  input  wire [ptrt_pkg::SLOT_W-1:0]        in_slot_index,
  input  wire [ptrt_pkg::TIME_W-1:0]        in_load_start_delay,
  input  wire [ptrt_pkg::TIME_W-1:0]        in_load_period,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [ptrt_pkg::MASK_W-1:0]       out_fired_mask,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [ptrt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire [ptrt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ptrt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import ptrt_pkg::*;

  logic [TICK_W-1:0] tick_r;
  cmd_t              cmd;
  status_t           status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_TICK_LENGTH) begin
      tick_r <= pwdata[TICK_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_TICK_LENGTH) ? CFG_DATA_W'(tick_r) : '0;

  ptrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ptrt_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_slot_index       (in_slot_index),
    .in_load_start_delay (in_load_start_delay),
    .in_load_period      (in_load_period),
    .tick_length         (tick_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_fired_mask      (out_fired_mask)
  );

endmodule
`default_nettype wire

@@ tb/ptrt_checker.sv @@
// Checker: predicts fired masks of the release timer from accepted requests and compares results.
`timescale 1ns / 1ps
`default_nettype none
module ptrt_checker (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  input  wire                                  in_stall,
  input  wire                                  in_mode,
  input  wire [ptrt_pkg::SLOT_W-1:0]           in_slot_index,
  input  wire [ptrt_pkg::TIME_W-1:0]           in_load_start_delay,
  input  wire [ptrt_pkg::TIME_W-1:0]           in_load_period,
  input  wire                                  out_valid,
  input  wire                                  out_stall,
  input  wire [ptrt_pkg::MASK_W-1:0]           out_fired_mask,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire                                  pready,
  input  wire [ptrt_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire [ptrt_pkg::CFG_DATA_W-1:0]       pwdata,
  output int                                   fail_count,
  output int                                   pending
);
  import ptrt_pkg::*;

  logic [TIME_W-1:0]  slot_remaining [NUM_TASKS];
  logic [TIME_W-1:0]  slot_reload    [NUM_TASKS];
  logic               slot_armed     [NUM_TASKS];
  logic [TICK_W-1:0]  tick_len;
  logic [MASK_W-1:0]  expected_masks [$];

  initial fail_count = 0;
  assign pending = expected_masks.size();

  // One tick over all slots; returns the slots that fire.
  function automatic logic [MASK_W-1:0] advance_timers();
    logic [MASK_W-1:0] fired;
    fired = '0;
    for (int s = 0; s < NUM_TASKS; s++) begin
      if (slot_remaining[s] == '0) begin
        if (slot_armed[s]) begin
          if (s < MASK_W) fired[s] = 1'b1;
          slot_remaining[s] = slot_reload[s];
        end
      end else if (slot_remaining[s] <= TIME_W'(tick_len)) begin
        slot_remaining[s] = '0;
      end else begin
        slot_remaining[s] = slot_remaining[s] - TIME_W'(tick_len);
      end
    end
    return fired;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_TASKS; s++) begin
        slot_remaining[s] = '0;
        slot_reload[s]    = '0;
        slot_armed[s]     = 1'b0;
      end
      tick_len = TICK_RESET;
      expected_masks.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TICK_LENGTH)
        tick_len = pwdata[TICK_W-1:0];
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_LOAD) begin
          if (int'(in_slot_index) < NUM_TASKS) begin
            slot_remaining[in_slot_index] = in_load_start_delay;
            slot_reload[in_slot_index]    = in_load_period;
            slot_armed[in_slot_index]     = 1'b1;
          end
          expected_masks.push_back('0);
        end else begin
          expected_masks.push_back(advance_timers());
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_masks.size() == 0) begin
          $error("unexpected result: fired_mask %0h", out_fired_mask);
          fail_count++;
        end else begin
          if (out_fired_mask !== expected_masks[0]) begin
            $error("fired_mask mismatch: expected %0h actual %0h",
                   expected_masks[0], out_fired_mask);
            fail_count++;
          end
          void'(expected_masks.pop_front());
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/periodic_task_release_timer_top_test.sv @@
// Testbench top: drives timer requests and register writes, reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_release_timer_top_test;
  import ptrt_pkg::*;

  localparam int DRAIN_CYCLES = NUM_TASKS + 8;
  localparam int PHASE_ITEMS  = 280;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_mode = MODE_TICK;
  logic [SLOT_W-1:0]      in_slot_index = '0;
  logic [TIME_W-1:0]      in_load_start_delay = '0;
  logic [TIME_W-1:0]      in_load_period = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MASK_W-1:0]      out_fired_mask;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  int                     fail_count;
  int                     pending;
  int                     readback_errors = 0;
  int                     idle_pct = 26;
  int                     stall_pct = 26;
  logic [TICK_W-1:0]      cur_tick;

  periodic_task_release_timer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_slot_index(in_slot_index), .in_load_start_delay(in_load_start_delay),
    .in_load_period(in_load_period),
    .out_valid(out_valid), .out_stall(out_stall), .out_fired_mask(out_fired_mask),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ptrt_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_slot_index(in_slot_index), .in_load_start_delay(in_load_start_delay),
    .in_load_period(in_load_period),
    .out_valid(out_valid), .out_stall(out_stall), .out_fired_mask(out_fired_mask),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_request(input logic mode, input logic [SLOT_W-1:0] slot,
                              input logic [TIME_W-1:0] delay,
                              input logic [TIME_W-1:0] period);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_slot_index       <= slot;
    in_load_start_delay <= delay;
    in_load_period      <= period;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic tick(input int n);
    repeat (n) send_request(MODE_TICK, SLOT_W'($urandom), TIME_W'($urandom),
                            TIME_W'($urandom));
  endtask

  task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] delay,
                           input logic [TIME_W-1:0] period);
    send_request(MODE_LOAD, slot, delay, period);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_tick_length(input logic [TICK_W-1:0] len);
    logic [CFG_DATA_W-1:0] rd;
    wait_idle();
    apb_access(1'b1, ADDR_TICK_LENGTH, CFG_DATA_W'(len), rd);
    @(posedge clk);
    apb_access(1'b0, ADDR_TICK_LENGTH, '0, rd);
    if (rd[TICK_W-1:0] !== len) begin
      $error("tick_length_ms readback mismatch: expected %0h actual %0h",
             len, rd[TICK_W-1:0]);
      readback_errors++;
    end
    cur_tick = len;
    @(posedge clk);
  endtask

  // Mostly delays of a few ticks so slots fire often; some full-range values.
  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    int span;
    r = $urandom_range(99);
    span = (cur_tick == 0) ? 4 : 6 * int'(cur_tick);
    if (r < 12) return '0;
    if (r < 80) return TIME_W'($urandom_range(span, 1));
    return TIME_W'($urandom);
  endfunction

  task automatic random_phase(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 22)
        load_slot(SLOT_W'($urandom), pick_time(), pick_time());
      else
        tick(1);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] rd;
    cur_tick = TICK_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unloaded slots, zero delay/period, reload, extremes, underflow
    apb_access(1'b0, ADDR_TICK_LENGTH, '0, rd);
    if (rd[TICK_W-1:0] !== TICK_RESET) begin
      $error("tick_length_ms reset mismatch: expected %0h actual %0h",
             TICK_RESET, rd[TICK_W-1:0]);
      readback_errors++;
    end
    @(posedge clk);
    tick(2);
    load_slot(3'd0, 16'd0, 16'd0);
    tick(3);
    load_slot(3'd7, 16'hFFFF, 16'hFFFF);
    load_slot(3'd3, 16'd2, 16'd1);
    tick(4);
    load_slot(3'd0, 16'd1, 16'd3);
    tick(3);
    set_tick_length(8'hFF);
    load_slot(3'd3, 16'd2, 16'd300);
    tick(4);
    set_tick_length(8'h00);
    tick(2);

    // random phases over several tick lengths
    random_phase(PHASE_ITEMS);
    set_tick_length(8'hFF);
    random_phase(PHASE_ITEMS);
    set_tick_length(TICK_W'($urandom_range(254, 2)));
    idle_pct  = 0;
    stall_pct = 0;
    random_phase(PHASE_ITEMS);
    idle_pct  = 26;
    stall_pct = 26;
    set_tick_length(8'h01);
    random_phase(PHASE_ITEMS);
    set_tick_length(8'h02);
    random_phase(PHASE_ITEMS);
    set_tick_length(TICK_W'($urandom));
    random_phase(PHASE_ITEMS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && readback_errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
